// File: sv/gsf_pkg.sv
// Package: shared types, constants and widths for the scanline fill unit.
`default_nettype none
package gsf_pkg;
   localparam int NumVerticesDefault = 4;
   localparam int GridSideDefault    = 32;
   localparam int MaxOut             = 32;
   localparam int CoordW             = 5;
   localparam int IntenW             = 8;
   localparam int IdxW               = 2;
   localparam int FracW              = 16;
   // Q16 values: x and intensity up to 2^13 magnitude after extrapolation,
   // slopes up to 2^24; 48 bits covers every intermediate.
   localparam int ValW               = 48;

   typedef struct packed {
      logic              mode;
      logic [IdxW-1:0]   vertex_index;
      logic [CoordW-1:0] vertex_x;
      logic [CoordW-1:0] vertex_y;
      logic [IntenW-1:0] vertex_intensity;
      logic [CoordW-1:0] scan_y;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] pixel_x;
      logic [CoordW-1:0] pixel_y;
      logic [IntenW-1:0] color_index;
      logic              span_end;
   } rsp_type;

   // datapath operation codes
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_EDGE,
      OP_PAIR,
      OP_EDGE_PREP,
      OP_EDGE_EVAL,
      OP_ORDER,
      OP_SPAN_PREP,
      OP_SPAN_START,
      OP_PIXEL
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic scan_last;
      logic pixel_last;
      logic in_grid_row;
   } status_type;
endpackage
`default_nettype wire

// File: sv/gsf_divider.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module gsf_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [gsf_pkg::ValW-1:0]  dividend,
   input  wire logic [gsf_pkg::ValW-1:0]  divisor,
   output logic                           done,
   output logic [gsf_pkg::ValW-1:0]       quotient
);
   import gsf_pkg::*;
   localparam int CntW = $clog2(ValW + 1);

   logic [ValW-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in, zero_ff, zero_in;
   logic [ValW:0]   trial;
   logic [ValW-1:0] shifted;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0; zero_in = zero_ff;
      shifted = {rem_ff[ValW-2:0], quo_ff[ValW-1]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (start) begin
         quo_in  = dividend[ValW-1] ? -dividend : dividend;
         den_in  = divisor[ValW-1] ? -divisor : divisor;
         neg_in  = dividend[ValW-1] ^ divisor[ValW-1];
         zero_in = (divisor == '0);
         rem_in  = '0;
         cnt_in  = CntW'(ValW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[ValW]) begin
            rem_in = trial[ValW-1:0];
            quo_in = {quo_ff[ValW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[ValW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : (neg_ff ? -quo_ff : quo_ff);
endmodule
`default_nettype wire

// File: sv/gsf_datapath.sv
// Datapath: vertex store, active pair, edge evaluation and span stepping.
`default_nettype none
module gsf_datapath #(
   parameter int NUM_VERTICES = gsf_pkg::NumVerticesDefault,
   parameter int GRID_SIDE    = gsf_pkg::GridSideDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gsf_pkg::req_type    req,
   input  wire gsf_pkg::cmd_type    cmd,
   input  wire logic                edge_sel,   // which edge / field being evaluated
   input  wire logic                field_sel,
   output gsf_pkg::status_type      status,
   output gsf_pkg::rsp_type         rsp_payload,
   output logic                     rsp_strobe
);
   import gsf_pkg::*;
   localparam int VW   = $clog2(NUM_VERTICES);
   localparam int OutW = $clog2(MaxOut + 1);

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [IntenW-1:0] inten;
   } vert_type;

   vert_type        store_ff [NUM_VERTICES];
   logic [VW-1:0]   top_ff [2], bot_ff [2], ctop_ff [2], cbot_ff [2];
   logic [1:0]      cnt_ff;
   logic [VW-1:0]   k_ff;
   logic [CoordW-1:0] line_ff;
   logic signed [ValW-1:0] dval_ff, base_ff, dyl_ff, slope_ff;
   logic signed [ValW-1:0] ev_ff [2][2];          // [edge][field]
   logic signed [ValW-1:0] li_ff, di_ff, ir_ff;
   logic signed [ValW-1:0] col_ff, end_ff;
   logic [OutW-1:0] n_ff;
   logic            strobe_ff;
   rsp_type         rsp_ff;
   logic            div_done;
   logic [ValW-1:0] quo, div_num, div_den;

   // combinational helpers
   logic [VW-1:0]   ka, kb, tv, bv, et, eb;
   logic            take;
   vert_type        vt, vb;
   logic signed [ValW-1:0] dy, nxt_li, nxt_col;
   logic            col_ok, emit, last_pix;
   // row offset is within +/-31, edge slope within +/-2^24
   logic signed [6:0]  row_off;
   logic signed [25:0] quo_s;
   logic signed [32:0] prod;

   always_comb begin
      ka = k_ff;
      kb = (k_ff == VW'(NUM_VERTICES - 1)) ? '0 : k_ff + 1'b1;
      if (store_ff[ka].y < store_ff[kb].y) begin
         tv = kb; bv = ka;
      end else begin
         tv = ka; bv = kb;
      end
      take = (store_ff[ka].y != store_ff[kb].y) && (cnt_ff < 2'd2) &&
             (line_ff >= store_ff[bv].y) && (line_ff < store_ff[tv].y);
      et = top_ff[edge_sel];
      eb = bot_ff[edge_sel];
      vt = store_ff[et];
      vb = store_ff[eb];
      dy = ValW'(signed'({1'b0, vt.y})) - ValW'(signed'({1'b0, vb.y}));
      row_off = slope_ff[6:0];
      quo_s   = quo[25:0];
      prod    = row_off * quo_s;
      nxt_li = li_ff + di_ff;
      if (di_ff < 0) begin
         if (nxt_li < ir_ff) nxt_li = ir_ff;
      end else if (nxt_li > ir_ff) begin
         nxt_li = ir_ff;
      end
      nxt_col  = col_ff + 1;
      col_ok   = (col_ff >= 0) && (col_ff < GRID_SIDE);
      emit     = col_ok && (col_ff <= end_ff);
      // no later column can be emitted: past the span, past the grid, or full
      last_pix = (nxt_col > end_ff) || (nxt_col >= GRID_SIDE) ||
                 (emit && n_ff == OutW'(MaxOut - 1));
   end

   assign div_num = cmd.op == OP_SPAN_PREP ?
                    ValW'((ev_ff[1][1] - ev_ff[0][1]) <<< FracW) : ValW'(dval_ff <<< FracW);
   assign div_den = cmd.op == OP_SPAN_PREP ? ValW'(ev_ff[1][0] - ev_ff[0][0]) : ValW'(dyl_ff);

   gsf_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(div_num), .divisor(div_den), .done(div_done), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '{default: '0};
         bot_ff    <= '{default: '0};
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == OP_PIXEL) && emit;
         case (cmd.op)
            OP_LOAD: begin
               if (!req.mode && 32'(req.vertex_index) < NUM_VERTICES)
                  store_ff[VW'(req.vertex_index)] <= {req.vertex_x, req.vertex_y,
                                                       req.vertex_intensity};
               line_ff <= req.scan_y;
               k_ff    <= '0;
               cnt_ff  <= '0;
            end
            OP_SCAN_EDGE: begin
               if (take) begin
                  ctop_ff[cnt_ff[0]] <= tv;
                  cbot_ff[cnt_ff[0]] <= bv;
                  cnt_ff <= cnt_ff + 1'b1;
               end
               k_ff <= k_ff + 1'b1;
            end
            OP_PAIR: begin
               if (cnt_ff == 2'd2) begin
                  top_ff <= ctop_ff;
                  bot_ff <= cbot_ff;
               end
            end
            OP_EDGE_PREP: begin
               // latch operands of current edge/field
               dval_ff <= field_sel ? ValW'(signed'({1'b0, vt.inten})) -
                                      ValW'(signed'({1'b0, vb.inten}))
                                    : ValW'(signed'({1'b0, vt.x})) -
                                      ValW'(signed'({1'b0, vb.x}));
               base_ff <= (field_sel ? ValW'(signed'({1'b0, vb.inten}))
                                     : ValW'(signed'({1'b0, vb.x}))) <<< FracW;
               dyl_ff  <= dy;
               slope_ff <= ValW'(signed'({1'b0, line_ff})) -
                           ValW'(signed'({1'b0, vb.y}));
            end
            OP_EDGE_EVAL: begin
               ev_ff[edge_sel][field_sel] <= base_ff + ValW'(prod);
            end
            OP_ORDER: begin
               if (ev_ff[0][0] > ev_ff[1][0]) begin
                  top_ff[0] <= top_ff[1]; top_ff[1] <= top_ff[0];
                  bot_ff[0] <= bot_ff[1]; bot_ff[1] <= bot_ff[0];
               end
            end
            OP_SPAN_START: begin
               li_ff  <= ev_ff[0][1];
               ir_ff  <= ev_ff[1][1];
               di_ff  <= (ev_ff[1][0] == ev_ff[0][0]) ? '0 : quo;
               col_ff <= (ev_ff[0][0] + (1 <<< (FracW - 1))) >>> FracW;
               end_ff <= (ev_ff[1][0] + (1 <<< (FracW - 1))) >>> FracW;
               n_ff   <= '0;
            end
            OP_PIXEL: begin
               if (emit) begin
                  rsp_ff.pixel_x     <= col_ff[CoordW-1:0];
                  rsp_ff.pixel_y     <= line_ff;
                  rsp_ff.color_index <= li_ff < 0 ? '0 :
                                        ((li_ff >>> FracW) > 255 ? 8'hFF
                                         : li_ff[FracW +: IntenW]);
                  rsp_ff.span_end    <= last_pix;
                  n_ff <= n_ff + 1'b1;
               end
               col_ff <= nxt_col;
               li_ff  <= nxt_li;
            end
            default: ;
         endcase
      end
   end

   // ordering needs the x values recomputed after a swap: the pair is
   // symmetric, so swap the evaluated values too is done by re-evaluation.
   assign status.div_done    = div_done;
   assign status.scan_last   = (k_ff == VW'(NUM_VERTICES - 1));
   assign status.pixel_last  = last_pix;
   assign status.in_grid_row = (32'(line_ff) < GRID_SIDE);
   assign rsp_payload = rsp_ff;
   assign rsp_strobe  = strobe_ff;
endmodule
`default_nettype wire

// File: sv/gsf_controller.sv
// Controller: sequences loading, edge search, edge evaluation and span walk.
`default_nettype none
module gsf_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               mode,
   input  wire gsf_pkg::status_type status,
   output gsf_pkg::cmd_type        cmd,
   output logic                    edge_sel,
   output logic                    field_sel,
   output logic                    busy
);
   import gsf_pkg::*;
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN, S_PAIR, S_PREP, S_DIV, S_EVAL, S_ORDER, S_SPDIV,
      S_SPWAIT, S_SPSTART, S_PIXEL
   } state_type;

   state_type state_ff;
   logic      edge_ff, field_ff, pass_ff;

   always_comb begin
      cmd = '{op: OP_NONE, div_start: 1'b0};
      case (state_ff)
         S_IDLE:    if (start) cmd.op = OP_LOAD;
         S_SCAN:    cmd.op = OP_SCAN_EDGE;
         S_PAIR:    cmd.op = OP_PAIR;
         S_PREP:    cmd.op = OP_EDGE_PREP;
         S_DIV:     cmd.div_start = 1'b1;
         S_EVAL:    if (status.div_done) cmd.op = OP_EDGE_EVAL;
         S_ORDER:   cmd.op = OP_ORDER;
         S_SPDIV:   begin cmd.op = OP_SPAN_PREP; cmd.div_start = 1'b1; end
         S_SPWAIT:  cmd.op = OP_SPAN_PREP;
         S_SPSTART: cmd.op = OP_SPAN_START;
         S_PIXEL:   cmd.op = OP_PIXEL;
         default:   ;
      endcase
   end

   // evaluation runs twice: first x of both edges for ordering (pass 0),
   // then all four values after ordering (pass 1). Pair latch happens once.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edge_ff <= 1'b0; field_ff <= 1'b0; pass_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (start) begin
               state_ff <= mode ? S_CHECK : S_IDLE;
            end
            S_CHECK: state_ff <= status.in_grid_row ? S_SCAN : S_IDLE;
            S_SCAN: if (status.scan_last) begin
               state_ff <= S_PAIR;
               edge_ff <= 1'b0; field_ff <= 1'b0; pass_ff <= 1'b0;
            end
            S_PAIR: state_ff <= S_PREP;   // new pair only with two active edges
            S_PREP: state_ff <= S_DIV;
            S_DIV:  state_ff <= S_EVAL;
            S_EVAL: if (status.div_done) begin
               if (!pass_ff) begin
                  if (edge_ff) begin
                     state_ff <= S_ORDER;
                  end else begin
                     edge_ff <= 1'b1; state_ff <= S_PREP;
                  end
               end else begin
                  {edge_ff, field_ff} <= {edge_ff, field_ff} + 2'd1;
                  state_ff <= ({edge_ff, field_ff} == 2'd3) ? S_SPDIV : S_PREP;
               end
            end
            S_ORDER: begin
               pass_ff <= 1'b1; edge_ff <= 1'b0; field_ff <= 1'b0;
               state_ff <= S_PREP;
            end
            S_SPDIV:   state_ff <= S_SPWAIT;
            S_SPWAIT:  if (status.div_done) state_ff <= S_SPSTART;
            S_SPSTART: state_ff <= S_PIXEL;
            S_PIXEL:   if (status.pixel_last) state_ff <= S_IDLE;
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   assign edge_sel  = edge_ff;
   assign field_sel = field_ff;
   assign busy      = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// File: sv/gouraud_scanline_fill_unit.sv
// Top level: Gouraud scanline fill unit, controller plus datapath.
`default_nettype none
// A load transfer never raises busy. A render holds busy through the row check, edge
// search, pair latch, edge divisions (both x values, then all four values) and a span
// division on one shared 48-bit serial divider (one quotient bit a cycle), then span
// column steps; an off-grid row holds busy only for the row check. Each pixel strobes
// the cycle after its column step, the last one as busy falls. One item at a time;
// receiver cannot stall. Sync reset clears control and active pair.
module gouraud_scanline_fill_unit #(
   parameter int NUM_VERTICES = gsf_pkg::NumVerticesDefault,
   parameter int GRID_SIDE    = gsf_pkg::GridSideDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire gsf_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output gsf_pkg::rsp_type      rsp_payload
);
   import gsf_pkg::*;
   cmd_type    cmd;
   status_type status;
   logic       edge_sel, field_sel;

   // controller: one transfer accepted when start && !busy
   gsf_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(req_payload.mode),
      .status(status), .cmd(cmd), .edge_sel(edge_sel), .field_sel(field_sel),
      .busy(busy)
   );

   gsf_datapath #(.NUM_VERTICES(NUM_VERTICES), .GRID_SIDE(GRID_SIDE)) u_dp (
      .clock(clock), .reset(reset), .req(req_payload), .cmd(cmd),
      .edge_sel(edge_sel), .field_sel(field_sel), .status(status),
      .rsp_payload(rsp_payload), .rsp_strobe(rsp_strobe)
   );
endmodule
`default_nettype wire

// File: sv/gsf_checker.sv
// Port-level checker for the scanline fill unit, bound to the top level.
`default_nettype none
module gsf_port_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire gsf_pkg::req_type req_payload,
   input wire logic             rsp_strobe,
   input wire gsf_pkg::rsp_type rsp_payload
);
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_payload.mode) |=> !rsp_strobe) else $error("load gave result");
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.span_end |-> busy) else $error("result outside render");
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.span_end |=> !rsp_strobe) else $error("result after end");
   a_row_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) |-> rsp_payload.pixel_y == $past(rsp_payload.pixel_y))
      else $error("row changed in span");
endmodule

bind gouraud_scanline_fill_unit gsf_port_checker u_gsf_checker (.*);
`default_nettype wire

// File: sim/gsf_checker.sv
// Checker: predicts scanline pixels from accepted requests and compares results.
`default_nettype none
module gsf_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire gsf_pkg::req_type req_payload,
   input  wire logic             rsp_strobe,
   input  wire gsf_pkg::rsp_type rsp_payload,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import gsf_pkg::*;

   localparam int NumVert = NumVerticesDefault;
   localparam int Grid    = GridSideDefault;
   localparam longint One = 65536;
   localparam longint Half = 32768;

   longint  vx [NumVert];
   longint  vy [NumVert];
   longint  vi [NumVert];
   int      pair_top [2];
   int      pair_bot [2];
   rsp_type pixel_queue [$];
   int      mismatch_count;

   function automatic longint floor_q16(longint v);
      if (v >= 0) return v / One;
      return -((-v + (One - 1)) / One);
   endfunction

   // Q16 x (use_inten=0) or intensity along active edge e at the given row
   function automatic longint edge_value(int e, longint row, bit use_inten);
      longint dy, d, slope, ft, fb;
      dy = vy[pair_top[e]] - vy[pair_bot[e]];
      ft = use_inten ? vi[pair_top[e]] : vx[pair_top[e]];
      fb = use_inten ? vi[pair_bot[e]] : vx[pair_bot[e]];
      d = ft - fb;
      slope = (dy != 0) ? (d * One) / dy : 0;
      return fb * One + (row - vy[pair_bot[e]]) * slope;
   endfunction

   task automatic render_scanline(longint row);
      int      found_top [2];
      int      found_bot [2];
      int      found, a, b, t, u, emitted;
      longint  xl, il, xr, ir, step, li, col, first, last, c;
      rsp_type pix;
      found = 0;
      if (row >= Grid) return;
      for (int k = 0; k < NumVert && found < 2; k++) begin
         a = k;
         b = (k + 1) % NumVert;
         if (vy[a] != vy[b]) begin
            if (vy[a] < vy[b]) begin
               t = b; u = a;
            end else begin
               t = a; u = b;
            end
            if (row >= vy[u] && row < vy[t]) begin
               found_top[found] = t;
               found_bot[found] = u;
               found++;
            end
         end
      end
      // fewer than two active edges: previous pair is reused
      if (found == 2) begin
         pair_top = found_top;
         pair_bot = found_bot;
      end
      if (edge_value(0, row, 0) > edge_value(1, row, 0)) begin
         t = pair_top[0]; u = pair_bot[0];
         pair_top[0] = pair_top[1]; pair_bot[0] = pair_bot[1];
         pair_top[1] = t; pair_bot[1] = u;
      end
      xl = edge_value(0, row, 0);
      il = edge_value(0, row, 1);
      xr = edge_value(1, row, 0);
      ir = edge_value(1, row, 1);
      step = (xr != xl) ? ((ir - il) * One) / (xr - xl) : 0;
      first = floor_q16(xl + Half);
      last  = floor_q16(xr + Half);
      li = il;
      emitted = 0;
      for (col = first; col <= last && emitted < MaxOut; col++) begin
         if (col >= 0 && col < Grid) begin
            if (li < 0) c = 0;
            else begin
               c = li / One;
               if (c > 255) c = 255;
            end
            pix.pixel_x     = col[CoordW-1:0];
            pix.pixel_y     = row[CoordW-1:0];
            pix.color_index = c[IntenW-1:0];
            pix.span_end    = 1'b0;
            pixel_queue.push_back(pix);
            emitted++;
         end
         li += step;
         if (step < 0) begin
            if (li < ir) li = ir;
         end else if (li > ir) li = ir;
      end
      if (emitted > 0) pixel_queue[pixel_queue.size()-1].span_end = 1'b1;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      mismatch_count = 0;
      for (int k = 0; k < NumVert; k++) begin
         vx[k] = 0; vy[k] = 0; vi[k] = 0;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_pix;
      if (reset) begin
         pair_top = '{0, 0};
         pair_bot = '{0, 0};
         pixel_queue.delete();
      end else begin
         if (rsp_strobe) begin
            if (pixel_queue.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected pixel: x=%0d y=%0d color=%0d end=%0b",
                           rsp_payload.pixel_x, rsp_payload.pixel_y,
                           rsp_payload.color_index, rsp_payload.span_end);
            end else begin
               exp_pix = pixel_queue.pop_front();
               if (rsp_payload !== exp_pix) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"pixel mismatch: exp x=%0d y=%0d c=%0d e=%0b, ",
                               "got x=%0d y=%0d c=%0d e=%0b"},
                              exp_pix.pixel_x, exp_pix.pixel_y, exp_pix.color_index,
                              exp_pix.span_end, rsp_payload.pixel_x, rsp_payload.pixel_y,
                              rsp_payload.color_index, rsp_payload.span_end);
               end
            end
         end
         if (start && !busy) begin
            if (req_payload.mode == 1'b0) begin
               if (int'(req_payload.vertex_index) < NumVert) begin
                  vx[req_payload.vertex_index] = req_payload.vertex_x;
                  vy[req_payload.vertex_index] = req_payload.vertex_y;
                  vi[req_payload.vertex_index] = req_payload.vertex_intensity;
               end
            end else render_scanline(longint'(req_payload.scan_y));
         end
      end
      pending_count = pixel_queue.size();
   end
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench top: stimulus, clock, reset, watchdog and verdict for the fill unit.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsf_pkg::*;

   localparam int ItemTarget = 410;
   localparam int StallLimit = 10000;  // cycles with no transfer and no pixel
   localparam int ReqW       = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_count;
   int      idle_pct;        // sender gap probability in percent
   int      item_count;
   int      stall_cycles;

   gouraud_scanline_fill_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   gsf_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: counts cycles where neither a request nor a pixel transfers.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type random_req();
      logic [ReqW-1:0] raw;
      raw = ReqW'($urandom);
      return req_type'(raw);
   endfunction

   // Called at a falling edge. Optional gap, then hold start until the
   // transfer edge; returns at the following falling edge.
   task automatic send_item(req_type item);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      item_count++;
      @(negedge clock);
   endtask

   task automatic load_vertex(int idx, int x, int y, int inten);
      req_type item;
      item                  = random_req();
      item.mode             = 1'b0;
      item.vertex_index     = idx[IdxW-1:0];
      item.vertex_x         = x[CoordW-1:0];
      item.vertex_y         = y[CoordW-1:0];
      item.vertex_intensity = inten[IntenW-1:0];
      send_item(item);
   endtask

   task automatic render_row(int row);
      req_type item;
      item        = random_req();
      item.mode   = 1'b1;
      item.scan_y = row[CoordW-1:0];
      send_item(item);
   endtask

   task automatic load_random_polygon();
      for (int k = 0; k < NumVerticesDefault; k++)
         load_vertex(k, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 255));
   endtask

   // Random phase: mostly polygon loads followed by several rows, some noise.
   task automatic random_burst();
      req_type noise;
      if ($urandom_range(0, 9) == 0) begin
         noise = random_req();
         send_item(noise);
      end else begin
         load_random_polygon();
         repeat ($urandom_range(2, 6)) render_row($urandom_range(0, 31));
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idle_pct    = 32;
      item_count  = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: quad touching both intensity extremes
      load_vertex(0, 2, 1, 0);
      load_vertex(1, 31, 10, 255);
      load_vertex(2, 20, 31, 128);
      load_vertex(3, 0, 20, 60);
      render_row(0);                 // below the polygon, keeps reset pair
      render_row(1);
      render_row(15);
      render_row(30);
      render_row(31);                // top line: fewer than two active edges
      // full-width span with horizontal top and bottom edges
      load_vertex(0, 0, 0, 255);
      load_vertex(1, 31, 0, 0);
      load_vertex(2, 31, 31, 255);
      load_vertex(3, 0, 31, 0);
      render_row(0);
      render_row(16);
      // degenerate: all vertices on one row, previous pair extrapolated
      load_vertex(0, 31, 5, 255);
      load_vertex(1, 0, 5, 0);
      load_vertex(2, 10, 5, 9);
      load_vertex(3, 25, 5, 200);
      render_row(0);
      render_row(31);

      while (item_count < ItemTarget) begin
         idle_pct = (item_count < ItemTarget / 3) ? 32 :
                    (item_count < 2 * ItemTarget / 3) ? 71 : 0;
         random_burst();
      end
      start <= 1'b0;

      while (pending_count != 0 || busy) @(negedge clock);
      repeat (400) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
